@@ sv/tfp_pkg.sv @@
package tfp_pkg;

  // size of the font name stores
  localparam int FONT_BYTES = 64;
  localparam int ADDR_W     = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
  // character counter, wide enough to hold the depth and the colour digit count
  localparam int CNT_W      = ($clog2(FONT_BYTES) + 1 > 4) ? $clog2(FONT_BYTES) + 1 : 4;
  localparam int LEN_W      = 6;
  localparam int SIZE_W     = 33;
  localparam int PROD_W     = 36;
  localparam int COLOR_W    = 24;
  localparam int HEX_DIGITS = 6;

  // tag letters, lower case
  localparam logic [7:0] LT_Y = 8'h79;
  localparam logic [7:0] LT_C = 8'h63;
  localparam logic [7:0] LT_F = 8'h66;
  localparam logic [7:0] LT_S = 8'h73;
  localparam logic [7:0] LT_H = 8'h68;
  localparam logic [7:0] LT_P = 8'h70;
  localparam logic [7:0] LT_O = 8'h6F;

  // style letters
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_U = 8'h75;

  // separators, prefixes and digit bounds
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] HEX_TEN   = 8'h0A;

  // style bit positions
  localparam int ST_ITALIC = 0;
  localparam int ST_BOLD   = 1;
  localparam int ST_UNDER  = 2;
  localparam int ST_STRIKE = 3;

  typedef struct packed {
    logic [7:0] tag_letter;
    logic [7:0] value_char;
    logic       char_present;
    logic       value_end;
  } item_t;

  typedef struct packed {
    logic [3:0]         styles;
    logic [COLOR_W-1:0] color;
    logic               color_set;
    logic [31:0]        size;
    logic               size_set;
    logic               font_set;
    logic [LEN_W-1:0]   font_len;
  } fmt_t;

  typedef struct packed {
    logic               malformed;
    logic               recognized;
    logic [3:0]         style_bits;
    logic [COLOR_W-1:0] color_rgb;
    logic               color_set;
    logic [31:0]        font_size;
    logic               size_set;
    logic               font_set;
    logic [LEN_W-1:0]   font_name_length;
    logic [7:0]         font_byte;
    logic               run_end;
  } res_t;

  // staging store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // font run start request
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] len;
  } run_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    lower_ascii = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
  endfunction

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] lc;
    lc = lower_ascii(c);
    if (c >= CH_0 && c <= CH_9) begin
      hex_nibble = {1'b1, c[3:0]};
    end else if (lc >= CH_LO_A && lc <= CH_LO_F) begin
      hex_nibble = {1'b1, 4'(lc - CH_LO_A + HEX_TEN)};
    end else begin
      hex_nibble = 5'd0;
    end
  endfunction

endpackage

@@ sv/tfp_if.sv @@
interface tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_letter;
  logic [7:0] value_char;
  logic       char_present;
  logic       value_end;

  modport source (output valid, tag_letter, value_char, char_present, value_end,
                  input ready);
  modport sink (input valid, tag_letter, value_char, char_present, value_end,
                output ready);
endinterface

interface tfp_out_if;
  logic        valid;
  logic        ready;
  logic        malformed;
  logic        recognized;
  logic [3:0]  style_bits;
  logic [23:0] color_rgb;
  logic        color_set;
  logic [31:0] font_size;
  logic        size_set;
  logic        font_set;
  logic [5:0]  font_name_length;
  logic [7:0]  font_byte;
  logic        run_end;

  modport source (output valid, malformed, recognized, style_bits, color_rgb, color_set,
                  font_size, size_set, font_set, font_name_length, font_byte, run_end,
                  input ready);
  modport sink (input valid, malformed, recognized, style_bits, color_rgb, color_set,
                font_size, size_set, font_set, font_name_length, font_byte, run_end,
                output ready);
endinterface

@@ sv/tfp_tag_engine.sv @@
module tfp_tag_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  tfp_pkg::item_t item,
  output tfp_pkg::fmt_t  fmt,
  output logic           sum_valid,
  output tfp_pkg::res_t  sum,
  output tfp_pkg::wr_t   wr,
  output tfp_pkg::run_t  run
);
  import tfp_pkg::*;

  logic               in_tag;
  logic [7:0]         active_letter;
  logic [CNT_W-1:0]   char_count;
  logic [COLOR_W-1:0] col_acc;
  logic [SIZE_W-1:0]  size_acc;
  logic [3:0]         pending_styles;
  logic               error_seen;
  logic               color_prefix;

  logic [7:0]         letter;
  logic [7:0]         lc;
  logic [4:0]         hx;
  logic [CNT_W-1:0]   cnt_b, cnt_next, pos_adj, digits;
  logic [COLOR_W-1:0] col_b, col_next;
  logic [SIZE_W-1:0]  size_b, size_next;
  logic [PROD_W-1:0]  size_prod;
  logic [3:0]         pend_b, pend_next;
  logic               err_b, err_next, pfx_b, pfx_next;
  logic               bad, rec, font_ok;
  fmt_t               fmt_next;
  logic [CNT_W+LEN_W-1:0] len_ext;

  // character step on the running accumulators
  always_comb begin
    letter    = in_tag ? active_letter : lower_ascii(item.tag_letter);
    cnt_b     = in_tag ? char_count : '0;
    col_b     = in_tag ? col_acc : '0;
    size_b    = in_tag ? size_acc : '0;
    pend_b    = in_tag ? pending_styles : '0;
    err_b     = in_tag ? error_seen : 1'b0;
    pfx_b     = in_tag ? color_prefix : 1'b0;
    cnt_next  = cnt_b;
    col_next  = col_b;
    size_next = size_b;
    pend_next = pend_b;
    err_next  = err_b;
    pfx_next  = pfx_b;
    wr        = '0;
    lc        = lower_ascii(item.value_char);
    hx        = hex_nibble(item.value_char);
    pos_adj   = cnt_b - CNT_W'(pfx_b);
    size_prod = (PROD_W'(size_b[31:0]) << 3) + (PROD_W'(size_b[31:0]) << 1)
              + PROD_W'(item.value_char[3:0]);
    if (item.char_present) begin
      case (letter)
        LT_Y: begin
          if (lc == CH_I) begin
            pend_next[ST_ITALIC] = 1'b1;
          end else if (lc == CH_B) begin
            pend_next[ST_BOLD] = 1'b1;
          end else if (lc == CH_U) begin
            pend_next[ST_UNDER] = 1'b1;
          end else if (lc == LT_S) begin
            pend_next[ST_STRIKE] = 1'b1;
          end else if (lc != CH_COMMA && lc != CH_SPACE && lc != CH_TAB) begin
            err_next = 1'b1;
          end
        end
        LT_C: begin
          if (cnt_b == '0 && (item.value_char == CH_DOLLAR || item.value_char == CH_HASH)) begin
            pfx_next = 1'b1;
          end else if (!hx[4]) begin
            err_next = 1'b1;
          end else if (pos_adj < CNT_W'(HEX_DIGITS)) begin
            col_next = {col_b[COLOR_W-5:0], hx[3:0]};
          end
        end
        LT_F: begin
          if (cnt_b < CNT_W'(FONT_BYTES - 1)) begin
            wr.en   = 1'b1;
            wr.addr = cnt_b[ADDR_W-1:0];
            wr.data = item.value_char;
          end
        end
        LT_S: begin
          if (item.value_char < CH_0 || item.value_char > CH_9) begin
            err_next = 1'b1;
          end else if (!size_b[SIZE_W-1]) begin
            if (size_prod[PROD_W-1:32] != '0) begin
              size_next = {1'b1, 32'd0};
            end else begin
              size_next = size_prod[SIZE_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
      // counter sticks at its top value
      if (cnt_b != '1) begin
        cnt_next = cnt_b + CNT_W'(1);
      end
    end
  end

  // commit on the last character
  always_comb begin
    fmt_next = fmt;
    bad      = 1'b0;
    rec      = 1'b1;
    font_ok  = 1'b0;
    digits   = cnt_next - CNT_W'(pfx_next);
    len_ext  = {{LEN_W{1'b0}}, cnt_next};
    case (letter)
      LT_Y: begin
        bad = err_next;
        if (!bad) begin
          fmt_next.styles = pend_next;
        end
      end
      LT_C: begin
        bad = err_next || digits != CNT_W'(HEX_DIGITS);
        if (!bad) begin
          fmt_next.color     = {col_next[7:0], col_next[15:8], col_next[23:16]};
          fmt_next.color_set = 1'b1;
        end
      end
      LT_F: begin
        bad = cnt_next == '0 || cnt_next >= CNT_W'(FONT_BYTES);
        if (!bad) begin
          font_ok           = 1'b1;
          fmt_next.font_set = 1'b1;
          fmt_next.font_len = len_ext[LEN_W-1:0];
        end
      end
      LT_S: begin
        bad = err_next || cnt_next == '0 || size_next == '0 || size_next[SIZE_W-1];
        if (!bad) begin
          fmt_next.size     = size_next[31:0];
          fmt_next.size_set = 1'b1;
        end
      end
      LT_H, LT_P, LT_O: begin
      end
      default: begin
        rec = 1'b0;
      end
    endcase
  end

  // summary result and font run request
  always_comb begin
    sum_valid            = accept && item.value_end && !font_ok;
    sum.malformed        = bad;
    sum.recognized       = rec;
    sum.style_bits       = fmt_next.styles;
    sum.color_rgb        = fmt_next.color;
    sum.color_set        = fmt_next.color_set;
    sum.font_size        = fmt_next.size;
    sum.size_set         = fmt_next.size_set;
    sum.font_set         = fmt_next.font_set;
    sum.font_name_length = fmt_next.font_len;
    sum.font_byte        = 8'd0;
    sum.run_end          = 1'b1;
    run.start            = accept && item.value_end && font_ok;
    run.len              = cnt_next[ADDR_W-1:0];
  end

  // tag state and kept format
  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag         <= 1'b0;
      active_letter  <= '0;
      char_count     <= '0;
      col_acc        <= '0;
      size_acc       <= '0;
      pending_styles <= '0;
      error_seen     <= 1'b0;
      color_prefix   <= 1'b0;
      fmt            <= '0;
    end else if (accept) begin
      in_tag         <= !item.value_end;
      active_letter  <= letter;
      char_count     <= cnt_next;
      col_acc        <= col_next;
      size_acc       <= size_next;
      pending_styles <= pend_next;
      error_seen     <= err_next;
      color_prefix   <= pfx_next;
      if (item.value_end) begin
        fmt <= fmt_next;
      end
    end
  end

endmodule

@@ sv/tfp_font_reader.sv @@
module tfp_font_reader (
  input  logic          clk,
  input  logic          rst,
  input  tfp_pkg::wr_t  wr,
  input  tfp_pkg::run_t run,
  input  logic          take,
  output logic          busy,
  output logic          rd_valid,
  output logic [7:0]    rd_byte,
  output logic          rd_last
);
  import tfp_pkg::*;

  logic [7:0]        staging [FONT_BYTES];
  logic              issuing;
  logic [ADDR_W-1:0] issue_idx;
  logic [ADDR_W-1:0] run_len;
  logic              rd_en;
  logic              at_end;

  assign at_end = issue_idx == run_len - ADDR_W'(1);
  assign rd_en  = issuing && (!rd_valid || take);
  assign busy   = issuing || rd_valid;

  // staging store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      staging[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_byte <= staging[issue_idx];
      rd_last <= at_end;
    end
  end

  // read sequencer over the font bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_idx <= '0;
      run_len   <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (run.start) begin
        issuing   <= 1'b1;
        issue_idx <= '0;
        run_len   <= run.len;
      end else if (rd_en) begin
        issue_idx <= issue_idx + ADDR_W'(1);
        if (at_end) begin
          issuing <= 1'b0;
        end
      end
      if (rd_en) begin
        rd_valid <= 1'b1;
      end else if (take) begin
        rd_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/tfp_out_buffer.sv @@
module tfp_out_buffer (
  input  logic          clk,
  input  logic          rst,
  input  logic          prod_valid,
  input  tfp_pkg::res_t prod,
  output logic          skid_full,
  tfp_out_if.source     result
);
  import tfp_pkg::*;

  logic out_valid;
  res_t out_data;
  res_t skid_data;
  logic out_free;

  assign out_free  = !out_valid || result.ready;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      out_valid <= skid_full || prod_valid;
      skid_full <= skid_full && prod_valid;
    end else if (prod_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data  <= skid_full ? skid_data : prod;
      skid_data <= prod;
    end else if (prod_valid) begin
      skid_data <= prod;
    end
  end

  assign result.valid            = out_valid;
  assign result.malformed        = out_data.malformed;
  assign result.recognized       = out_data.recognized;
  assign result.style_bits       = out_data.style_bits;
  assign result.color_rgb        = out_data.color_rgb;
  assign result.color_set        = out_data.color_set;
  assign result.font_size        = out_data.font_size;
  assign result.size_set         = out_data.size_set;
  assign result.font_set         = out_data.font_set;
  assign result.font_name_length = out_data.font_name_length;
  assign result.font_byte        = out_data.font_byte;
  assign result.run_end          = out_data.run_end;

endmodule

@@ sv/subtitle_format_tag_parser.sv @@
// Parses subtitle formatting tags (y style, c colour, f font name, s size; h, p and o are
// taken and ignored) fed one value character per request, and keeps the current format.
// Every request that is not the last of its tag gives no result; the last one gives one
// summary result. A good font tag of N bytes instead gives N results, one font byte each,
// read back from the staging store through its single read port: the first passes the read
// and output registers, and the rest follow one a cycle while the output side takes them.
// No new request is taken until the last of them has left the read stage. A skid entry
// behind the output register lets requests keep flowing while one result waits.
module subtitle_format_tag_parser (
  input  logic     clk,
  input  logic     rst,
  tfp_in_if.sink   item,
  tfp_out_if.source result
);
  import tfp_pkg::*;

  item_t item_data;
  logic  accept;
  fmt_t  fmt;
  logic  sum_valid;
  res_t  sum;
  wr_t   wr;
  run_t  run;
  logic  busy;
  logic  rd_valid;
  logic  rd_last;
  logic  rd_take;
  logic [7:0] rd_byte;
  logic  skid_full;
  logic  prod_valid;
  res_t  prod;

  assign item_data = '{tag_letter: item.tag_letter, value_char: item.value_char,
                       char_present: item.char_present, value_end: item.value_end};
  assign item.ready = !busy && !skid_full;
  assign accept     = item.valid && item.ready;
  assign rd_take    = rd_valid && !skid_full;

  tfp_tag_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item_data),
    .fmt       (fmt),
    .sum_valid (sum_valid),
    .sum       (sum),
    .wr        (wr),
    .run       (run)
  );

  tfp_font_reader u_reader (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .run      (run),
    .take     (rd_take),
    .busy     (busy),
    .rd_valid (rd_valid),
    .rd_byte  (rd_byte),
    .rd_last  (rd_last)
  );

  // font run results carry the kept format, summaries come from the engine
  always_comb begin
    prod_valid = sum_valid || rd_take;
    if (rd_take) begin
      prod.malformed        = 1'b0;
      prod.recognized       = 1'b1;
      prod.style_bits       = fmt.styles;
      prod.color_rgb        = fmt.color;
      prod.color_set        = fmt.color_set;
      prod.font_size        = fmt.size;
      prod.size_set         = fmt.size_set;
      prod.font_set         = fmt.font_set;
      prod.font_name_length = fmt.font_len;
      prod.font_byte        = rd_byte;
      prod.run_end          = rd_last;
    end else begin
      prod = sum;
    end
  end

  tfp_out_buffer u_out (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .skid_full  (skid_full),
    .result     (result)
  );

endmodule

@@ verif/subtitle_format_tag_parser_test.sv @@
module subtitle_format_tag_parser_test;
  import tfp_pkg::*;

  localparam int          QUIET_LIMIT  = 3000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          RANDOM_ITEMS = 80;
  localparam int          COUNT_CAP    = 'hFFFF;
  localparam logic [63:0] SIZE_MAX     = 64'hFFFF_FFFF;
  localparam logic [63:0] SIZE_OVER    = 64'h1_0000_0000;

  // tracks the kept format and the open tag, and holds the results still to come
  class format_scoreboard;
    logic [3:0]  styles;
    logic [23:0] color;
    bit          color_ok;
    logic [31:0] size;
    bit          size_ok;
    int unsigned font_len;
    bit          font_ok;
    logic [7:0]  staged [FONT_BYTES];
    logic [7:0]  letter;
    bit          open;
    int unsigned count;
    logic [63:0] acc;
    logic [3:0]  pend;
    bit          err;
    bit          prefixed;
    res_t        awaited [$];
    int          errors;

    function new();
      styles = '0; color = '0; color_ok = 0; size = '0; size_ok = 0;
      font_len = 0; font_ok = 0; letter = '0; open = 0; count = 0;
      acc = '0; pend = '0; err = 0; prefixed = 0; errors = 0;
      foreach (staged[k]) staged[k] = '0;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      if (c >= CH_UP_A && c <= CH_UP_Z) return c + CASE_GAP;
      return c;
    endfunction

    function int hex_of(logic [7:0] c);
      logic [7:0] lc;
      lc = fold_case(c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (lc >= CH_LO_A && lc <= CH_LO_F) return int'(lc - CH_LO_A) + 10;
      return -1;
    endfunction

    // one value character into the open tag
    function void take_char(logic [7:0] ch);
      logic [7:0]  lc;
      int          d;
      int unsigned pos;
      lc  = fold_case(ch);
      pos = count;
      case (letter)
        LT_Y: begin
          if (lc == CH_I) pend[ST_ITALIC] = 1'b1;
          else if (lc == CH_B) pend[ST_BOLD] = 1'b1;
          else if (lc == CH_U) pend[ST_UNDER] = 1'b1;
          // strike is the same letter as the size tag
          else if (lc == LT_S) pend[ST_STRIKE] = 1'b1;
          else if (lc != CH_COMMA && lc != CH_SPACE && lc != CH_TAB) err = 1'b1;
        end
        LT_C: begin
          if (pos == 0 && (ch == CH_DOLLAR || ch == CH_HASH)) begin
            prefixed = 1'b1;
          end else begin
            d = hex_of(ch);
            if (d < 0) err = 1'b1;
            else if (pos - prefixed < HEX_DIGITS) acc = ((acc << 4) | 64'(d)) & 64'hFF_FFFF;
          end
        end
        LT_F: begin
          if (pos < FONT_BYTES - 1) staged[pos] = ch;
        end
        LT_S: begin
          if (ch < CH_0 || ch > CH_9) begin
            err = 1'b1;
          end else if (acc < SIZE_OVER) begin
            acc = acc * 10 + 64'(ch - CH_0);
            if (acc > SIZE_MAX) acc = SIZE_OVER;
          end
        end
        default: ;
      endcase
      if (count < COUNT_CAP) count++;
    endfunction

    function res_t make_result(bit bad, bit rec, logic [7:0] fb, bit fin);
      res_t r;
      r.malformed        = bad;
      r.recognized       = rec;
      r.style_bits       = styles;
      r.color_rgb        = color;
      r.color_set        = color_ok;
      r.font_size        = size;
      r.size_set         = size_ok;
      r.font_set         = font_ok;
      r.font_name_length = LEN_W'(font_len);
      r.font_byte        = fb;
      r.run_end          = fin;
      return r;
    endfunction

    // accepted request: advance the tag and queue whatever it yields
    function void note_request(item_t it);
      bit          bad;
      bit          rec;
      int unsigned digits;
      bad = 0;
      rec = 1;
      if (!open) begin
        letter = fold_case(it.tag_letter);
        count = 0; acc = '0; pend = '0; err = 0; prefixed = 0;
        open = 1;
      end
      if (it.char_present) take_char(it.value_char);
      if (!it.value_end) return;
      open = 0;
      case (letter)
        LT_Y: begin
          bad = err;
          if (!bad) styles = pend;
        end
        LT_C: begin
          digits = count - prefixed;
          bad = err || digits != HEX_DIGITS;
          // digits arrive blue first
          if (!bad) begin
            color    = {acc[7:0], acc[15:8], acc[23:16]};
            color_ok = 1;
          end
        end
        LT_F: begin
          bad = count == 0 || count >= FONT_BYTES;
          if (!bad) begin
            font_len = count;
            font_ok  = 1;
            for (int k = 0; k < font_len; k++)
              awaited.push_back(make_result(1'b0, 1'b1, staged[k], k + 1 == font_len));
            return;
          end
        end
        LT_S: begin
          bad = err || count == 0 || acc == 0 || acc > SIZE_MAX;
          if (!bad) begin
            size    = acc[31:0];
            size_ok = 1;
          end
        end
        LT_H, LT_P, LT_O: ;
        default: rec = 0;
      endcase
      awaited.push_back(make_result(bad, rec, 8'h00, 1'b1));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("mismatch: %s", what);
    endtask

    task check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = awaited.pop_front();
      check_field("malformed", 32'(got.malformed), 32'(want.malformed));
      check_field("recognized", 32'(got.recognized), 32'(want.recognized));
      check_field("style_bits", 32'(got.style_bits), 32'(want.style_bits));
      check_field("color_rgb", 32'(got.color_rgb), 32'(want.color_rgb));
      check_field("color_set", 32'(got.color_set), 32'(want.color_set));
      check_field("font_size", got.font_size, want.font_size);
      check_field("size_set", 32'(got.size_set), 32'(want.size_set));
      check_field("font_set", 32'(got.font_set), 32'(want.font_set));
      check_field("font_name_length", 32'(got.font_name_length),
                  32'(want.font_name_length));
      check_field("font_byte", 32'(got.font_byte), 32'(want.font_byte));
      check_field("run_end", 32'(got.run_end), 32'(want.run_end));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  bit   calm = 0;
  bit   hold_now = 0;
  int   sent = 0;
  int   quiet = 0;
  res_t seen_result;
  logic [7:0] tag_text [$];
  format_scoreboard sb;

  tfp_in_if  in_ch ();
  tfp_out_if out_ch ();

  subtitle_format_tag_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  assign seen_result = {out_ch.malformed, out_ch.recognized, out_ch.style_bits,
                        out_ch.color_rgb, out_ch.color_set, out_ch.font_size,
                        out_ch.size_set, out_ch.font_set, out_ch.font_name_length,
                        out_ch.font_byte, out_ch.run_end};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, plus a long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  // compare each accepted result
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.check_result(seen_result);
  end

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(logic [7:0] letter, logic [7:0] ch, bit present, bit fin);
    item_t it;
    int    gap;
    it.tag_letter   = letter;
    it.value_char   = ch;
    it.char_present = present;
    it.value_end    = fin;
    gap = 0;
    while (!calm && $urandom_range(99) < 24) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.tag_letter   <= it.tag_letter;
    in_ch.value_char   <= it.value_char;
    in_ch.char_present <= it.char_present;
    in_ch.value_end    <= it.value_end;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
    sb.note_request(it);
  endtask

  // drop valid and let every queued result come out
  task automatic park_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // send tag_text as one tag; later letters are junk, and a few empty requests slip in
  task automatic send_tag(logic [7:0] letter);
    if (tag_text.size() == 0) begin
      send_request(letter, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int k = 0; k < tag_text.size(); k++) begin
      if ($urandom_range(99) < 4)
        send_request(k == 0 ? letter : 8'($urandom), 8'($urandom), 1'b0, 1'b0);
      send_request(k == 0 ? letter : 8'($urandom), tag_text[k], 1'b1,
                   k == tag_text.size() - 1);
    end
  endtask

  function automatic logic [7:0] any_case(logic [7:0] lc);
    return $urandom_range(1) ? lc - CASE_GAP : lc;
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  function automatic void text_of(string s);
    tag_text.delete();
    for (int k = 0; k < s.len(); k++) tag_text.push_back(s[k]);
  endfunction

  function automatic void noise_text(int len);
    tag_text.delete();
    repeat (len) tag_text.push_back(8'($urandom));
  endfunction

  function automatic void spoil_text();
    if (tag_text.size() > 0) tag_text[$urandom_range(tag_text.size() - 1)] = 8'($urandom);
  endfunction

  function automatic void style_text(int len);
    logic [7:0] c;
    tag_text.delete();
    repeat (len) begin
      case ($urandom_range(6))
        0: c = any_case(CH_I);
        1: c = any_case(CH_B);
        2: c = any_case(CH_U);
        3: c = any_case(LT_S);
        4: c = CH_COMMA;
        5: c = CH_SPACE;
        default: c = CH_TAB;
      endcase
      tag_text.push_back(c);
    end
  endfunction

  // prefix: 0 none, 1 dollar, 2 hash
  function automatic void colour_text(int digits, int prefix);
    tag_text.delete();
    if (prefix == 1) tag_text.push_back(CH_DOLLAR);
    else if (prefix == 2) tag_text.push_back(CH_HASH);
    repeat (digits) tag_text.push_back(hex_char($urandom_range(15)));
  endfunction

  function automatic void size_text(logic [63:0] v, int zeros);
    tag_text.delete();
    do begin
      tag_text.push_front(CH_0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    repeat (zeros) tag_text.push_front(CH_0);
  endfunction

  // one random tag, mostly well formed
  task automatic random_tag();
    int          pick;
    int          len;
    int          r;
    logic [63:0] v;
    logic [7:0]  odd;
    logic [7:0]  lo;
    pick = $urandom_range(99);
    if (pick < 20) begin
      style_text($urandom_range(6));
      if ($urandom_range(99) < 10) spoil_text();
      send_tag(any_case(LT_Y));
    end else if (pick < 40) begin
      colour_text(($urandom_range(99) < 80) ? HEX_DIGITS : $urandom_range(8),
                  $urandom_range(2));
      if ($urandom_range(99) < 8) spoil_text();
      send_tag(any_case(LT_C));
    end else if (pick < 58) begin
      r = $urandom_range(99);
      if (r < 92) len = $urandom_range(8, 1);
      else if (r < 96) len = $urandom_range(FONT_BYTES - 1, FONT_BYTES - 8);
      else if (r < 98) len = $urandom_range(FONT_BYTES + 6, FONT_BYTES);
      else len = 0;
      noise_text(len);
      send_tag(any_case(LT_F));
    end else if (pick < 78) begin
      case ($urandom_range(5))
        0: v = 64'($urandom_range(999, 1));
        1: v = 64'($urandom);
        2: v = SIZE_MAX;
        3: v = '0;
        4: v = SIZE_OVER + 64'($urandom);
        default: v = {$urandom, $urandom};
      endcase
      size_text(v, ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0);
      if ($urandom_range(99) < 8) spoil_text();
      send_tag(any_case(LT_S));
    end else if (pick < 88) begin
      noise_text($urandom_range(4));
      case ($urandom_range(2))
        0: send_tag(any_case(LT_H));
        1: send_tag(any_case(LT_P));
        default: send_tag(any_case(LT_O));
      endcase
    end else begin
      // any letter that is not a known control
      do begin
        odd = 8'($urandom);
        lo  = (odd >= CH_UP_A && odd <= CH_UP_Z) ? odd + CASE_GAP : odd;
      end while (lo inside {LT_Y, LT_C, LT_F, LT_S, LT_H, LT_P, LT_O});
      noise_text($urandom_range(4));
      send_tag(odd);
    end
  endtask

  initial begin
    int  base;
    bit  held;
    sb = new();
    held = 0;
    in_ch.valid        = 1'b0;
    in_ch.tag_letter   = '0;
    in_ch.value_char   = '0;
    in_ch.char_present = 1'b0;
    in_ch.value_end    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // styles: empty value clears, every letter, separators, a bad character
    text_of("");       send_tag(LT_Y - CASE_GAP);
    text_of("iBuS");   send_tag(LT_Y);
    text_of("b, i\tu"); send_tag(LT_Y);
    text_of("bx");     send_tag(LT_Y);
    // colour: both prefixes, none, too few digits, prefix alone, empty
    text_of("$0000FF"); send_tag(LT_C);
    text_of("#aBcDeF"); send_tag(LT_C - CASE_GAP);
    text_of("123456");  send_tag(LT_C);
    text_of("12345");   send_tag(LT_C);
    text_of("$");       send_tag(LT_C);
    text_of("");        send_tag(LT_C);
    // size: largest, one past it, zero, empty, leading zeros after a characterless start
    text_of("4294967295"); send_tag(LT_S - CASE_GAP);
    text_of("4294967296"); send_tag(LT_S);
    text_of("0");          send_tag(LT_S);
    text_of("");           send_tag(LT_S);
    send_request(LT_S, 8'hFF, 1'b0, 1'b0);
    text_of("007");        send_tag(8'h00);
    // font: a zero byte, empty
    tag_text = {8'h00};
    send_tag(LT_F);
    text_of("");            send_tag(LT_F);
    // ignored and unknown letters
    text_of("zz"); send_tag(LT_H);
    text_of("");   send_tag(LT_P - CASE_GAP);
    text_of("1");  send_tag(LT_O);
    text_of("q");  send_tag(8'hFF);
    text_of("");   send_tag(8'h00);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      // hold the result side while single-request tags pile up, then drain
      if (!held && sent - base >= 10) begin
        held = 1;
        hold_now = 1'b1;
        repeat (24) begin
          noise_text(1);
          send_tag(8'($urandom));
        end
        park_input();
      end
      calm = (sent - base >= 40 && sent - base < 70);
      random_tag();
    end
    calm = 0;
    park_input();
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
